FILE: rtl/csr_pkg.sv
package csr_pkg;

  localparam int unsigned MaxBytes = 65536;
  localparam int unsigned AddrW = $clog2(MaxBytes);
  localparam int unsigned LenW = $clog2(MaxBytes + 1);

  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] FnvPrime = 64'h00000100000001b3;

  typedef enum logic [2:0] {
    KIND_BEGIN  = 3'd0,
    KIND_CHUNK  = 3'd1,
    KIND_COMMIT = 3'd2,
    KIND_SETHST = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_STALE    = 3'd1,
    ST_REJECTED = 3'd2,
    ST_RESET    = 3'd3,
    ST_STAGED   = 3'd4,
    ST_HOSTCHG  = 3'd5
  } status_t;

  // One request as it crosses from the front part to the back part.
  typedef struct packed {
    logic [2:0]  kind;
    logic        src_ok;
    logic [63:0] source_actor;
    logic [63:0] link_nonce;
    logic [31:0] epoch;
    logic [63:0] session_rev;
    logic [63:0] snap_rev;
    logic [31:0] xfer_id;
    logic [31:0] total_len;
    logic [31:0] position;
    logic [63:0] digest;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic            read_pending;
  } rsp_t;

endpackage

FILE: rtl/csr_front.sv
// Source check: holds host identity, tags each request with src_ok.
module csr_front import csr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [63:0] source_actor,
  input  logic [63:0] link_nonce,
  input  logic [31:0] epoch,
  input  logic [63:0] session_rev,
  input  logic [63:0] snap_rev,
  input  logic [31:0] xfer_id,
  input  logic [31:0] total_len,
  input  logic [31:0] position,
  input  logic [63:0] digest,
  input  logic [7:0]  data_byte,
  output logic        q_valid,
  output req_t        q_req,
  input  logic        q_stall
);

  logic [63:0] host_expected;
  logic [63:0] host_latched;
  logic [63:0] host_expected_next;
  logic [63:0] host_latched_next;
  logic        src_ok;
  logic [63:0] host;
  logic        take;

  assign in_stall = q_valid && q_stall;
  assign take = in_valid && !in_stall;

  always_comb begin
    host_expected_next = host_expected;
    host_latched_next = host_latched;
    src_ok = 1'b0;
    host = (host_expected != 64'd0) ? host_expected : host_latched;
    if (kind <= KIND_COMMIT) begin
      if (kind == KIND_BEGIN && host_expected == 64'd0 && host_latched == 64'd0) begin
        // A sane first begin latches its source, which then trivially matches.
        if (source_actor != 64'd0 && link_nonce != 64'd0) begin
          src_ok = 1'b1;
          host_latched_next = source_actor;
        end
      end else begin
        src_ok = source_actor != 64'd0 && host != 64'd0 && host == source_actor;
      end
    end else if (kind == KIND_SETHST && source_actor != 64'd0) begin
      // For set-host, src_ok low marks a change away from the latched host.
      src_ok = host_latched == 64'd0 || host_latched == source_actor;
      host_expected_next = source_actor;
      if (host_latched == 64'd0 || host_latched != source_actor)
        host_latched_next = source_actor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      host_expected <= '0;
      host_latched <= '0;
      q_valid <= 1'b0;
    end else begin
      if (take) begin
        host_expected <= host_expected_next;
        host_latched <= host_latched_next;
        q_valid <= 1'b1;
      end else if (!q_stall) begin
        q_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_req.kind <= kind;
      q_req.src_ok <= src_ok;
      q_req.source_actor <= source_actor;
      q_req.link_nonce <= link_nonce;
      q_req.epoch <= epoch;
      q_req.session_rev <= session_rev;
      q_req.snap_rev <= snap_rev;
      q_req.xfer_id <= xfer_id;
      q_req.total_len <= total_len;
      q_req.position <= position;
      q_req.digest <= digest;
      q_req.data_byte <= data_byte;
    end
  end

endmodule

FILE: rtl/csr_back.sv
// Transfer engine: begin/chunk/commit, hash, bank memory, output register.
module csr_back import csr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  req_t        q_req,
  output logic        q_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  read_value,
  output logic        staged_valid,
  output logic [16:0] staged_length
);

  logic [31:0]     accepted_epoch;
  logic [63:0]     accepted_session;
  logic [63:0]     accepted_revision;
  logic            rx_active;
  logic [31:0]     rx_epoch;
  logic [63:0]     rx_session;
  logic [63:0]     rx_revision;
  logic [31:0]     rx_transfer;
  logic [63:0]     rx_nonce;
  logic [63:0]     rx_digest;
  logic [LenW-1:0] rx_total;
  logic [LenW-1:0] rx_count;
  logic [63:0]     rx_running_hash;
  logic            bank_select;
  logic            staged_present;
  logic [LenW-1:0] staged_bytes;
  logic [7:0]      byte_banks [2*MaxBytes];

  logic            go;
  logic            id_match;
  logic            new_scope;
  logic [63:0]     eff_rev;
  logic [2:0]      st;
  logic            drop_rx;
  logic            open_rx;
  logic            chunk_ok;
  logic            commit_ok;
  logic            clr_all;
  logic            rd_hit;
  logic [AddrW:0]  rd_addr;
  logic [AddrW:0]  wr_addr;
  logic [63:0]     hash_x;
  logic [63:0]     hash_m;
  rsp_t            rsp;
  logic [7:0]      rd_data;

  assign q_stall = out_valid && out_stall;
  assign go = q_valid && !q_stall;

  assign id_match = rx_active && q_req.epoch == rx_epoch && q_req.session_rev == rx_session
                    && q_req.snap_rev == rx_revision && q_req.xfer_id == rx_transfer
                    && q_req.digest == rx_digest && q_req.link_nonce == rx_nonce;
  assign new_scope = q_req.epoch != accepted_epoch || q_req.session_rev != accepted_session;
  assign eff_rev = new_scope ? 64'd0 : accepted_revision;
  assign hash_x = rx_running_hash ^ {56'd0, q_req.data_byte};
  // FNV prime is 2^40 + 0x1b3: multiply by shift and add.
  assign hash_m = (hash_x << 40) + (hash_x << 8) + (hash_x << 7) + (hash_x << 5)
                  + (hash_x << 4) + (hash_x << 1) + hash_x;
  assign wr_addr = {~bank_select, rx_count[AddrW-1:0]};
  assign rd_addr = {bank_select, q_req.position[AddrW-1:0]};

  always_comb begin
    st = ST_ACCEPTED;
    drop_rx = 1'b0;
    open_rx = 1'b0;
    chunk_ok = 1'b0;
    commit_ok = 1'b0;
    clr_all = 1'b0;
    rd_hit = 1'b0;
    unique case (q_req.kind)
      KIND_BEGIN, KIND_CHUNK, KIND_COMMIT: begin
        if (!q_req.src_ok) begin
          st = ST_REJECTED;
        end else if (q_req.kind == KIND_BEGIN) begin
          if (!new_scope && q_req.snap_rev < accepted_revision) begin
            st = ST_STALE;
          end else if (q_req.snap_rev <= eff_rev || q_req.link_nonce == 64'd0) begin
            st = ST_STALE;
          end else begin
            drop_rx = 1'b1;
            if (q_req.total_len > 32'(MaxBytes)) st = ST_RESET;
            else open_rx = 1'b1;
          end
        end else if (q_req.kind == KIND_CHUNK) begin
          if (id_match && q_req.position == 32'(rx_count) && rx_count < rx_total) begin
            chunk_ok = 1'b1;
          end else begin
            drop_rx = 1'b1;
            st = ST_RESET;
          end
        end else begin
          drop_rx = 1'b1;
          if (id_match && q_req.position == 32'(rx_total) && rx_count == rx_total
              && rx_running_hash == rx_digest) begin
            commit_ok = 1'b1;
            st = ST_STAGED;
          end else begin
            st = ST_RESET;
          end
        end
      end
      KIND_SETHST: begin
        // Front already moved the host ids; a change of host here wipes state.
        if (q_req.source_actor != 64'd0 && !q_req.src_ok) begin
          clr_all = 1'b1;
          st = ST_HOSTCHG;
        end
      end
      KIND_READ: begin
        rd_hit = staged_present && q_req.position < 32'(staged_bytes);
      end
      default: st = ST_STALE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_epoch <= '0;
      accepted_session <= '0;
      accepted_revision <= '0;
      rx_active <= 1'b0;
      rx_epoch <= '0;
      rx_session <= '0;
      rx_revision <= '0;
      rx_transfer <= '0;
      rx_nonce <= '0;
      rx_digest <= '0;
      rx_total <= '0;
      rx_count <= '0;
      rx_running_hash <= FnvBasis;
      bank_select <= 1'b0;
      staged_present <= 1'b0;
      staged_bytes <= '0;
      out_valid <= 1'b0;
      rsp <= '0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
        if (q_req.kind == KIND_BEGIN && q_req.src_ok && new_scope) begin
          accepted_epoch <= q_req.epoch;
          accepted_session <= q_req.session_rev;
          accepted_revision <= '0;
          staged_present <= 1'b0;
          staged_bytes <= '0;
        end
        if (open_rx) begin
          rx_active <= 1'b1;
          rx_epoch <= q_req.epoch;
          rx_session <= q_req.session_rev;
          rx_revision <= q_req.snap_rev;
          rx_transfer <= q_req.xfer_id;
          rx_nonce <= q_req.link_nonce;
          rx_digest <= q_req.digest;
          rx_total <= LenW'(q_req.total_len);
          rx_count <= '0;
          rx_running_hash <= FnvBasis;
        end else if (drop_rx || clr_all) begin
          rx_active <= 1'b0;
          rx_epoch <= '0;
          rx_session <= '0;
          rx_revision <= '0;
          rx_transfer <= '0;
          rx_nonce <= '0;
          rx_digest <= '0;
          rx_total <= '0;
          rx_count <= '0;
          rx_running_hash <= FnvBasis;
        end
        if (chunk_ok) begin
          rx_running_hash <= hash_m;
          rx_count <= rx_count + 1'b1;
        end
        if (commit_ok) begin
          staged_present <= 1'b1;
          staged_bytes <= rx_total;
          bank_select <= ~bank_select;
          accepted_revision <= rx_revision;
        end
        if (clr_all) begin
          staged_present <= 1'b0;
          staged_bytes <= '0;
          accepted_epoch <= '0;
          accepted_session <= '0;
          accepted_revision <= '0;
        end
        rsp.status <= st;
        rsp.read_pending <= rd_hit;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && chunk_ok) byte_banks[wr_addr] <= q_req.data_byte;
    if (go && rd_hit) rd_data <= byte_banks[rd_addr];
  end

  assign status = rsp.status;
  assign read_value = rsp.read_pending ? rd_data : 8'd0;
  assign staged_valid = staged_present;
  assign staged_length = 17'(staged_bytes);

endmodule

FILE: rtl/chunked_snapshot_receiver.sv
// Chunked snapshot receiver, guest side.
// Input channel: in_valid/in_stall with one request per accepted edge
// (kind begin, chunk byte, commit, set host, read staged byte).
// Output channel: out_valid/out_stall, one result per request, in order:
// status, read_value, staged_valid, staged_length after that request.
// From acceptance to result a request passes the source-check front stage
// and then the transfer engine, whose bank memory read is registered.
// Throughput is one request per cycle while out_stall is low; the
// per-byte FNV-1a multiply and one bank write happen in the engine cycle.
// Two banks of 64 KiB hold the receiving and the staged snapshot; banks
// swap on a good commit. Memory needs no clearing: reads reach only
// bytes written by the staged transfer.
// Reset clears host ids, transfer and staged state; a result then appears
// only after a request. When out_stall is high the result holds, the
// engine holds, and in_stall rises once the one-entry queue is full.
module chunked_snapshot_receiver import csr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [63:0] source_actor,
  input  logic [63:0] link_nonce,
  input  logic [31:0] epoch,
  input  logic [63:0] session_rev,
  input  logic [63:0] snap_rev,
  input  logic [31:0] xfer_id,
  input  logic [31:0] total_len,
  input  logic [31:0] position,
  input  logic [63:0] digest,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  read_value,
  output logic        staged_valid,
  output logic [16:0] staged_length
);

  logic q_valid;
  logic q_stall;
  req_t q_req;

  csr_front u_front (
    .clk, .rst, .in_valid, .in_stall, .kind, .source_actor, .link_nonce, .epoch,
    .session_rev, .snap_rev, .xfer_id, .total_len, .position, .digest, .data_byte,
    .q_valid, .q_req, .q_stall
  );

  csr_back u_back (
    .clk, .rst, .q_valid, .q_req, .q_stall, .out_valid, .out_stall,
    .status, .read_value, .staged_valid, .staged_length
  );

endmodule

FILE: rtl/csr_checker.sv
module csr_checker import csr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [7:0]  read_value,
  input logic        staged_valid,
  input logic [16:0] staged_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_value))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_HOSTCHG)
    else $error("status code out of range");

  a_len_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !staged_valid |-> staged_length == 17'd0)
    else $error("length without staged snapshot");

  a_staged_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_STAGED |-> staged_valid)
    else $error("staged status without staged snapshot");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("result or stall right after reset");

endmodule

bind chunked_snapshot_receiver csr_checker u_checker (.*);

FILE: test/chunked_snapshot_receiver_checker.sv
`timescale 1ns / 1ps

module chunked_snapshot_receiver_checker import csr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [63:0] source_actor,
  input  logic [63:0] link_nonce,
  input  logic [31:0] epoch,
  input  logic [63:0] session_rev,
  input  logic [63:0] snap_rev,
  input  logic [31:0] xfer_id,
  input  logic [31:0] total_len,
  input  logic [31:0] position,
  input  logic [63:0] digest,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [7:0]  read_value,
  input  logic        staged_valid,
  input  logic [16:0] staged_length,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  value;
    logic        present;
    logic [16:0] length;
  } verdict_t;

  verdict_t verdicts[$];

  logic [63:0] host_set, host_seen;
  logic [31:0] ok_epoch;
  logic [63:0] ok_session, ok_rev;
  logic        xf_open;
  logic [31:0] xf_epoch, xf_id, xf_total, xf_count;
  logic [63:0] xf_session, xf_rev, xf_nonce, xf_digest, xf_hash;
  logic [7:0]  bank_mem [0:2*MaxBytes-1];
  logic        live_bank;
  logic        snap_present;
  logic [63:0] snap_revision;
  logic [31:0] snap_len;

  task clear_transfer();
    xf_open = 0; xf_epoch = 0; xf_session = 0; xf_rev = 0; xf_id = 0;
    xf_nonce = 0; xf_digest = 0; xf_total = 0; xf_count = 0; xf_hash = FnvBasis;
  endtask

  task clear_snapshot();
    snap_present = 0; snap_revision = 0; snap_len = 0;
  endtask

  function automatic logic same_transfer();
    return xf_open && epoch == xf_epoch && session_rev == xf_session &&
           snap_rev == xf_rev && xfer_id == xf_id && digest == xf_digest &&
           link_nonce == xf_nonce;
  endfunction

  task open_transfer(output status_t st);
    st = ST_ACCEPTED;
    if (snap_rev < ok_rev && epoch == ok_epoch && session_rev == ok_session) begin
      st = ST_STALE;
      return;
    end
    if (epoch != ok_epoch || session_rev != ok_session) begin
      ok_epoch = epoch; ok_session = session_rev; ok_rev = 0;
      clear_snapshot();
    end
    if (snap_rev <= ok_rev || link_nonce == 0) begin
      st = ST_STALE;
      return;
    end
    clear_transfer();
    if (total_len > MaxBytes) begin
      st = ST_RESET;
      return;
    end
    xf_open = 1; xf_epoch = epoch; xf_session = session_rev; xf_rev = snap_rev;
    xf_id = xfer_id; xf_nonce = link_nonce; xf_digest = digest; xf_total = total_len;
  endtask

  task predict(output verdict_t v);
    logic        src_ok, latched_now;
    logic [63:0] host;
    status_t     st;
    st = ST_ACCEPTED;
    v.value = 0;
    if (kind <= KIND_COMMIT) begin
      src_ok = 1;
      latched_now = 0;
      if (kind == KIND_BEGIN && host_set == 0 && host_seen == 0) begin
        if (source_actor == 0 || link_nonce == 0) src_ok = 0;
        else begin
          host_seen = source_actor;
          latched_now = 1;
        end
      end
      if (src_ok) begin
        host = host_set != 0 ? host_set : host_seen;
        if (source_actor == 0 || host == 0 || host != source_actor) begin
          if (latched_now) host_seen = 0;
          src_ok = 0;
        end
      end
      if (!src_ok) st = ST_REJECTED;
      else if (kind == KIND_BEGIN) open_transfer(st);
      else if (kind == KIND_CHUNK) begin
        if (!same_transfer() || position != xf_count || xf_count >= xf_total) begin
          clear_transfer();
          st = ST_RESET;
        end else begin
          bank_mem[{~live_bank, xf_count[AddrW-1:0]}] = data_byte;
          xf_hash = (xf_hash ^ {56'd0, data_byte}) * FnvPrime;
          xf_count++;
        end
      end else begin
        if (!same_transfer() || position != xf_total || xf_count != xf_total ||
            xf_hash != xf_digest) begin
          clear_transfer();
          st = ST_RESET;
        end else begin
          snap_present = 1; snap_revision = xf_rev; snap_len = xf_total;
          live_bank = ~live_bank;
          ok_rev = xf_rev;
          clear_transfer();
          st = ST_STAGED;
        end
      end
    end else if (kind == KIND_SETHST) begin
      if (source_actor != 0) begin
        if (host_seen != 0 && host_seen != source_actor) begin
          host_set = source_actor; host_seen = source_actor;
          clear_transfer();
          clear_snapshot();
          ok_epoch = 0; ok_session = 0; ok_rev = 0;
          st = ST_HOSTCHG;
        end else begin
          host_set = source_actor;
          if (host_seen == 0) host_seen = source_actor;
        end
      end
    end else if (kind == KIND_READ) begin
      if (snap_present && position < snap_len && position < MaxBytes)
        v.value = bank_mem[{live_bank, position[AddrW-1:0]}];
    end else begin
      st = ST_STALE;
    end
    v.status = st;
    v.present = snap_present;
    v.length = snap_len[16:0];
  endtask

  initial begin
    fails = 0;
    host_set = 0; host_seen = 0; ok_epoch = 0; ok_session = 0; ok_rev = 0;
    live_bank = 0;
    clear_transfer();
    clear_snapshot();
    for (int i = 0; i < 2 * MaxBytes; i++) bank_mem[i] = 0;
  end

  assign pending = verdicts.size();

  always @(posedge clk) begin
    verdict_t v, want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict(v);
        verdicts.push_back(v);
      end
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = verdicts.pop_front();
          if (status !== want.status) begin
            $error("status expected %0d got %0d", want.status, status);
            fails++;
          end
          if (read_value !== want.value) begin
            $error("read_value expected %0h got %0h", want.value, read_value);
            fails++;
          end
          if (staged_valid !== want.present) begin
            $error("staged_valid expected %0b got %0b", want.present, staged_valid);
            fails++;
          end
          if (staged_length !== want.length) begin
            $error("staged_length expected %0d got %0d", want.length, staged_length);
            fails++;
          end
        end
      end
    end
  end

endmodule

FILE: test/chunked_snapshot_receiver_test.sv
`timescale 1ns / 1ps

module chunked_snapshot_receiver_test;
  import csr_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] source_actor, link_nonce, session_rev, snap_rev, digest;
    logic [31:0] epoch, xfer_id, total_len, position;
    logic [7:0]  data_byte;
  } request_t;

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [2:0]  kind = 0, status;
  logic [63:0] source_actor = 0, link_nonce = 0, session_rev = 0, snap_rev = 0, digest = 0;
  logic [31:0] epoch = 0, xfer_id = 0, total_len = 0, position = 0;
  logic [7:0]  data_byte = 0, read_value;
  logic        staged_valid;
  logic [16:0] staged_length;
  int          fails, pending, sent, idle_cycles, burst_left;

  logic [63:0] host_id, nonce_id, cur_session, cur_rev;
  logic [31:0] cur_epoch, cur_xfer;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  chunked_snapshot_receiver dut (.*);
  chunked_snapshot_receiver_checker checker_i (.*);

  // Watchdog: cycles with no request or result moving.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall modes plus one long hold-off.
  initial begin
    int mode, span, cyc;
    logic long_done;
    long_done = 0;
    cyc = 0;
    @(negedge rst);
    forever begin
      if (!long_done && cyc > 800) begin
        long_done = 1;
        repeat (400) @(posedge clk) out_stall <= 1;
        cyc += 400;
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          default: out_stall <= ($urandom_range(0, 99) < 70);
        endcase
      end
      cyc += span;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic request_t blank(logic [2:0] k);
    request_t r;
    r = '{default: 0};
    r.kind = k;
    r.source_actor = host_id;
    r.link_nonce = nonce_id;
    r.epoch = cur_epoch;
    r.session_rev = cur_session;
    r.snap_rev = cur_rev;
    r.xfer_id = cur_xfer;
    return r;
  endfunction

  task send(input request_t r);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1;
    kind <= r.kind; source_actor <= r.source_actor; link_nonce <= r.link_nonce;
    epoch <= r.epoch; session_rev <= r.session_rev; snap_rev <= r.snap_rev;
    xfer_id <= r.xfer_id; total_len <= r.total_len; position <= r.position;
    digest <= r.digest; data_byte <= r.data_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Full begin / chunk / commit sequence; flaw 0 is clean.
  task transfer(input int len, input int flaw);
    logic [7:0]  payload[$];
    logic [63:0] hash;
    request_t    r;
    int          bad_at;
    cur_rev += $urandom_range(1, 3);
    cur_xfer = $urandom;
    hash = FnvBasis;
    payload = {};
    for (int i = 0; i < len; i++) begin
      payload.push_back($urandom);
      hash = (hash ^ {56'd0, payload[i]}) * FnvPrime;
    end
    bad_at = len > 0 ? $urandom_range(0, len - 1) : 0;
    r = blank(KIND_BEGIN);
    r.total_len = len;
    r.digest = hash;
    send(r);
    for (int i = 0; i < len; i++) begin
      r = blank(KIND_CHUNK);
      r.digest = hash;
      r.position = i;
      r.data_byte = payload[i];
      if (i == bad_at && flaw == 1) r.data_byte = ~payload[i];
      if (i == bad_at && flaw == 2) r.position = i + 1;
      if (i == bad_at && flaw == 3) r.xfer_id = ~cur_xfer;
      send(r);
    end
    r = blank(KIND_COMMIT);
    r.digest = hash;
    r.position = (flaw == 4) ? len + 1 : len;
    send(r);
  endtask

  initial begin
    request_t r;
    int pick;
    logic paused;
    sent = 0;
    burst_left = 0;
    paused = 0;
    host_id = 64'hA5A5_0000_0000_0001;
    nonce_id = 64'h1;
    cur_epoch = 1; cur_session = 1; cur_rev = 0; cur_xfer = 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // Directed: no host, source checks, extremes and invalidation.
    r = blank(KIND_READ); send(r);
    r = blank(KIND_SETHST); r.source_actor = 0; send(r);
    r = blank(KIND_BEGIN); r.source_actor = 0; send(r);
    r = blank(KIND_BEGIN); r.link_nonce = 0; send(r);
    r = blank(KIND_CHUNK); send(r);
    transfer(3, 0);
    r = blank(KIND_BEGIN); r.source_actor = ~host_id; r.snap_rev = 64'd50; send(r);
    for (int i = 0; i < 4; i++) begin
      r = blank(KIND_READ); r.position = i; send(r);
    end
    r = blank(KIND_READ); r.position = '1; send(r);
    r = blank(KIND_BEGIN); send(r);
    r = blank(KIND_BEGIN); r.snap_rev = '1; r.total_len = MaxBytes + 1; send(r);
    r = blank(KIND_BEGIN); r.snap_rev = 64'd20; r.total_len = MaxBytes; send(r);
    r = blank(KIND_COMMIT); r.snap_rev = 64'd20; send(r);
    r = blank(3'd5); send(r);
    r = blank(3'd6); send(r);
    r = blank(3'd7); send(r);
    transfer(0, 0);
    nonce_id = '1;
    host_id = 64'h0000_0000_0000_0777;
    r = blank(KIND_SETHST); send(r);
    r = blank(KIND_SETHST); send(r);
    cur_rev = 0;

    while (sent < 1400) begin
      if (!paused && sent > 700) begin
        paused = 1;
        in_valid <= 0;
        burst_left = 0;
        wait (pending == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        transfer(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10),
                 ($urandom_range(0, 99) < 20) ? $urandom_range(1, 4) : 0);
      end else if (pick < 70) begin
        r = blank(KIND_READ); r.position = $urandom_range(0, 45); send(r);
      end else if (pick < 75) begin
        r = blank(KIND_SETHST);
        case ($urandom_range(0, 3))
          0: r.source_actor = 0;
          1: begin
            host_id = rand64();
            r.source_actor = host_id;
            cur_epoch = 0; cur_session = 0; cur_rev = 0;
          end
          default: ;
        endcase
        send(r);
      end else if (pick < 80) begin
        cur_epoch = $urandom_range(0, 3) == 0 ? $urandom : cur_epoch + 1;
        cur_session = $urandom_range(0, 1) ? rand64() : cur_session;
        cur_rev = 0;
        nonce_id = rand64() | 64'd1;
        r = blank(KIND_BEGIN); r.snap_rev = 0; send(r);
      end else if (pick < 85) begin
        r = blank(KIND_BEGIN);
        r.snap_rev = cur_rev - $urandom_range(0, 2);
        if ($urandom_range(0, 1)) r.link_nonce = 0;
        send(r);
      end else begin
        r.kind = $urandom_range(0, 7);
        r.source_actor = $urandom_range(0, 1) ? host_id : rand64();
        r.link_nonce = rand64(); r.epoch = $urandom; r.session_rev = rand64();
        r.snap_rev = rand64(); r.xfer_id = $urandom; r.total_len = $urandom;
        r.position = $urandom; r.digest = rand64(); r.data_byte = $urandom;
        if (r.kind == KIND_SETHST) r.source_actor = host_id;
        send(r);
      end
    end

    in_valid <= 0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
